/* rtl/core/lppc_pkg.sv */
// Shared types and constants of the lidar point projection and colorize block.
package lppc_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int SUM_W        = 64;
  localparam int PT_W         = 24;
  localparam int DIM_W        = 11;
  localparam int FIFO_DEPTH   = 32;
  localparam int CFG_AW       = 6;
  localparam int CFG_DW       = 64;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

  typedef enum logic [2:0] {
    REG_ROW0_LEFT,
    REG_ROW0_RIGHT,
    REG_ROW1_LEFT,
    REG_ROW1_RIGHT,
    REG_ROW2_LEFT,
    REG_ROW2_RIGHT,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_POINT = 1'b1
  } req_t;

  // Everything an item carries alongside the arithmetic.
  typedef struct packed {
    req_t            kind;
    logic [9:0]      pix_row;
    logic [9:0]      pix_col;
    logic [23:0]     rgb;
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic [PT_W-1:0] z;
    logic            same_u;
    logic            same_v;
    logic            wzero;
  } side_t;

endpackage

/* rtl/core/lppc_ram.sv */
// Generic single-port RAM with registered read data.
module lppc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/lppc_div.sv */
// Pipelined restoring divider: two magnitudes over one divisor, one quotient bit per stage.
module lppc_div #(
  parameter int QB = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [lppc_pkg::SUM_W-1:0] num_u,
  input  logic [lppc_pkg::SUM_W-1:0] num_v,
  input  logic [lppc_pkg::SUM_W-1:0] den,
  input  lppc_pkg::side_t            in_side,
  output logic                       out_valid,
  output logic [QB-1:0]              q_u,
  output logic [QB-1:0]              q_v,
  output logic                       ovf,
  output lppc_pkg::side_t            out_side
);

  localparam int RW = lppc_pkg::SUM_W + QB;

  logic [RW-1:0]              ru_r   [0:QB-1];
  logic [RW-1:0]              rv_r   [0:QB-1];
  logic [lppc_pkg::SUM_W-1:0] den_r  [0:QB-1];
  logic [QB-1:0]              qu_r   [0:QB];
  logic [QB-1:0]              qv_r   [0:QB];
  logic                       ovf_r  [0:QB];
  logic                       vld_r  [0:QB];
  lppc_pkg::side_t            side_r [0:QB];

  logic [RW-1:0] den_top;
  logic          ovf_in;

  // A quotient at or above 2**QB can never be inside the image.
  assign den_top = {den, {QB{1'b0}}};
  assign ovf_in  = (RW'(num_u) >= den_top) || (RW'(num_v) >= den_top);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    ru_r[0]   <= RW'(num_u);
    rv_r[0]   <= RW'(num_v);
    den_r[0]  <= den;
    qu_r[0]   <= '0;
    qv_r[0]   <= '0;
    ovf_r[0]  <= ovf_in;
    side_r[0] <= in_side;
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [RW-1:0] dsh;
    logic          ge_u;
    logic          ge_v;

    assign dsh  = RW'(den_r[j]) << (QB - 1 - j);
    assign ge_u = ru_r[j] >= dsh;
    assign ge_v = rv_r[j] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
      qu_r[j+1]   <= {qu_r[j][QB-2:0], ge_u};
      qv_r[j+1]   <= {qv_r[j][QB-2:0], ge_v};
      ovf_r[j+1]  <= ovf_r[j];
      side_r[j+1] <= side_r[j];
    end

    if (j < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        ru_r[j+1]  <= ge_u ? (ru_r[j] - dsh) : ru_r[j];
        rv_r[j+1]  <= ge_v ? (rv_r[j] - dsh) : rv_r[j];
        den_r[j+1] <= den_r[j];
      end
    end
  end

  assign out_valid = vld_r[QB];
  assign q_u       = qu_r[QB];
  assign q_v       = qv_r[QB];
  assign ovf       = ovf_r[QB];
  assign out_side  = side_r[QB];

endmodule

/* rtl/core/lidar_point_project_colorize_top.sv */
// Top level: lidar point projection into a stored camera frame and point colorization.
//
//   Channel | Direction | Handshake              | Transaction
//   in_     | slave     | in_tvalid / in_tready  | pixel write or lidar point
//   out_    | master    | out_tvalid / out_tready| colored point
//   cfg_    | APB slave | psel, penable, pready  | projection and image size registers
//
// One item is accepted per cycle while in_tready is high. A point passes nine
// multipliers, a two-level adder, a magnitude stage, a QB-stage restoring divider
// (QB = clog2 of the larger frame dimension), an address stage and one frame RAM
// read on its way to the result FIFO. Pixel writes follow the same path and write
// the RAM at the same stage where points read it, so reads and writes stay in order.
// Reset is synchronous and clears control state; the frame store is not cleared.
// The datapath never stalls; in_tready drops only when the items in flight plus the
// results waiting in the output FIFO fill its FIFO_DEPTH entries.
module lidar_point_project_colorize_top #(
  parameter int MAX_COLS = lppc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lppc_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pix_row[9:0], pix_col[19:10], pix_blue[27:20], pix_green[35:28], pix_red[43:36],
  // point_x[67:44], point_y[91:68], point_z[115:92], zero fill [119:116]
  input  logic [119:0]                in_tdata,
  // req_type[0]
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_x[23:0], out_y[47:24], out_z[71:48], color_red[79:72], color_green[87:80],
  // color_blue[95:88]
  output logic [95:0]                 out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lppc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [lppc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lppc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int QB    = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS);
  localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int CW    = (lppc_pkg::DIM_W > QB + 1) ? lppc_pkg::DIM_W : QB + 1;
  localparam int SW    = lppc_pkg::SUM_W;
  localparam int FD    = lppc_pkg::FIFO_DEPTH;
  localparam int FPW   = $clog2(FD);
  localparam int CNTW  = $clog2(FD + 1);

  // ---------------------------------------------------------------- configuration
  logic [63:0]                   proj_r [0:5];
  logic [lppc_pkg::DIM_W-1:0]    width_r;
  logic [lppc_pkg::DIM_W-1:0]    height_r;
  logic                          cfg_wr;
  lppc_pkg::cfg_reg_t            cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = lppc_pkg::cfg_reg_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        proj_r[i] <= '0;
      end
      width_r  <= lppc_pkg::WIDTH_RST;
      height_r <= lppc_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        lppc_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[lppc_pkg::DIM_W-1:0];
        lppc_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[lppc_pkg::DIM_W-1:0];
        default:                    proj_r[cfg_paddr[5:3]] <= cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      lppc_pkg::REG_IMAGE_WIDTH:  cfg_prdata = 64'(width_r);
      lppc_pkg::REG_IMAGE_HEIGHT: cfg_prdata = 64'(height_r);
      default:                    cfg_prdata = proj_r[cfg_paddr[5:3]];
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // Credits cover every item from accept until it is dropped or its result leaves.
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] cnt_nxt;
  logic            in_acc;
  logic            out_pop;
  logic            f_drop;

  assign in_tready = (cnt_r < CNTW'(FD));
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (f_drop) begin
      cnt_nxt = cnt_nxt - 1'b1;
    end
    if (out_pop) begin
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic            s1_vld_r;
  lppc_pkg::side_t s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
    s1_side_r.kind    <= lppc_pkg::req_t'(in_tuser);
    s1_side_r.pix_row <= in_tdata[9:0];
    s1_side_r.pix_col <= in_tdata[19:10];
    s1_side_r.rgb     <= {in_tdata[43:36], in_tdata[35:28], in_tdata[27:20]};
    s1_side_r.x       <= in_tdata[67:44];
    s1_side_r.y       <= in_tdata[91:68];
    s1_side_r.z       <= in_tdata[115:92];
    s1_side_r.same_u  <= 1'b0;
    s1_side_r.same_v  <= 1'b0;
    s1_side_r.wzero   <= 1'b0;
  end

  // ---------------------------------------------------------------- stage 2: products
  // Each Q8.16 by Q16.16 product is exact in 56 bits (Q.32).
  logic signed [55:0] p_r [0:2][0:2];
  logic               s2_vld_r;
  lppc_pkg::side_t    s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_side_r <= s1_side_r;
    for (int r = 0; r < 3; r++) begin
      p_r[r][0] <= $signed(s1_side_r.x) * $signed(proj_r[2*r][31:0]);
      p_r[r][1] <= $signed(s1_side_r.y) * $signed(proj_r[2*r][63:32]);
      p_r[r][2] <= $signed(s1_side_r.z) * $signed(proj_r[2*r+1][31:0]);
    end
  end

  // ---------------------------------------------------------------- stage 3: pair sums
  logic signed [SW-1:0] a_r [0:2];
  logic signed [SW-1:0] b_r [0:2];
  logic                 s3_vld_r;
  lppc_pkg::side_t      s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_side_r <= s2_side_r;
    for (int r = 0; r < 3; r++) begin
      a_r[r] <= SW'(p_r[r][0]) + SW'(p_r[r][1]);
      // The offset moves from Q16.16 to Q.32.
      b_r[r] <= SW'(p_r[r][2]) + (SW'($signed(proj_r[2*r+1][63:32])) <<< 16);
    end
  end

  // ---------------------------------------------------------------- stage 4: row sums
  logic signed [SW-1:0] sum_r [0:2];
  logic                 s4_vld_r;
  lppc_pkg::side_t      s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_side_r <= s3_side_r;
    for (int r = 0; r < 3; r++) begin
      sum_r[r] <= a_r[r] + b_r[r];
    end
  end

  // ---------------------------------------------------------------- stage 5: magnitudes
  // Truncation toward zero divides magnitudes; the signs only decide whether a
  // nonzero quotient is negative.
  logic [SW-1:0]   mag_u_r;
  logic [SW-1:0]   mag_v_r;
  logic [SW-1:0]   mag_w_r;
  logic            s5_vld_r;
  lppc_pkg::side_t s5_side_r;
  lppc_pkg::side_t s5_side_nxt;

  always_comb begin
    s5_side_nxt        = s4_side_r;
    s5_side_nxt.same_u = (sum_r[0][SW-1] == sum_r[2][SW-1]);
    s5_side_nxt.same_v = (sum_r[1][SW-1] == sum_r[2][SW-1]);
    s5_side_nxt.wzero  = (sum_r[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_side_r <= s5_side_nxt;
    mag_u_r <= sum_r[0][SW-1] ? SW'(-sum_r[0]) : SW'(sum_r[0]);
    mag_v_r <= sum_r[1][SW-1] ? SW'(-sum_r[1]) : SW'(sum_r[1]);
    mag_w_r <= sum_r[2][SW-1] ? SW'(-sum_r[2]) : SW'(sum_r[2]);
  end

  // ---------------------------------------------------------------- divider
  logic            d_vld;
  logic [QB-1:0]   q_col;
  logic [QB-1:0]   q_row;
  logic            d_ovf;
  lppc_pkg::side_t d_side;

  lppc_div #(
    .QB (QB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_vld_r),
    .num_u     (mag_u_r),
    .num_v     (mag_v_r),
    .den       (mag_w_r),
    .in_side   (s5_side_r),
    .out_valid (d_vld),
    .q_u       (q_col),
    .q_v       (q_row),
    .ovf       (d_ovf),
    .out_side  (d_side)
  );

  // ---------------------------------------------------------------- address stage
  logic            pt_ok;
  logic            px_ok;
  logic [AW-1:0]   row_sel;
  logic [AW-1:0]   col_sel;
  logic            e_vld_r;
  logic            e_ok_r;
  lppc_pkg::req_t  e_kind_r;
  logic [AW-1:0]   e_addr_r;
  logic [23:0]     e_rgb_r;
  logic [71:0]     e_xyz_r;

  // A zero quotient is in range whatever the signs.
  assign pt_ok = !d_side.wzero && !d_ovf
              && ((q_col == '0) || d_side.same_u)
              && ((q_row == '0) || d_side.same_v)
              && (CW'(q_col) < CW'(width_r))  && (CW'(q_col) < CW'(MAX_COLS))
              && (CW'(q_row) < CW'(height_r)) && (CW'(q_row) < CW'(MAX_ROWS));
  assign px_ok = (CW'(d_side.pix_row) < CW'(MAX_ROWS))
              && (CW'(d_side.pix_col) < CW'(MAX_COLS));

  assign row_sel = (d_side.kind == lppc_pkg::REQ_POINT) ? AW'(q_row) : AW'(d_side.pix_row);
  assign col_sel = (d_side.kind == lppc_pkg::REQ_POINT) ? AW'(q_col) : AW'(d_side.pix_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld;
    end
    e_kind_r <= d_side.kind;
    e_ok_r   <= (d_side.kind == lppc_pkg::REQ_POINT) ? pt_ok : px_ok;
    e_addr_r <= AW'(row_sel * AW'(MAX_COLS)) + col_sel;
    e_rgb_r  <= d_side.rgb;
    e_xyz_r  <= {d_side.z, d_side.y, d_side.x};
  end

  // ---------------------------------------------------------------- frame store
  logic        ram_we;
  logic [23:0] ram_rdata;

  assign ram_we = e_vld_r && e_ok_r && (e_kind_r == lppc_pkg::REQ_PIXEL);

  lppc_ram #(
    .WIDTH (24),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (e_addr_r),
    .wdata (e_rgb_r),
    .rdata (ram_rdata)
  );

  logic        f_vld_r;
  logic        f_push_r;
  logic [71:0] f_xyz_r;
  logic        f_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= e_vld_r;
    end
    f_push_r <= e_ok_r && (e_kind_r == lppc_pkg::REQ_POINT);
    f_xyz_r  <= e_xyz_r;
  end

  assign f_push = f_vld_r && f_push_r;
  assign f_drop = f_vld_r && !f_push_r;

  // ---------------------------------------------------------------- result FIFO
  logic [95:0]     fifo_mem [0:FD-1];
  logic [FPW-1:0]  wptr_r;
  logic [FPW-1:0]  rptr_r;
  logic [CNTW-1:0] fcnt_r;

  assign out_tvalid = (fcnt_r != '0);
  assign out_pop    = out_tvalid && out_tready;
  assign out_tdata  = fifo_mem[rptr_r];

  always_ff @(posedge clk) begin
    if (f_push) begin
      // Colors are doubled modulo 256: blue, green, red from the top byte down.
      fifo_mem[wptr_r] <= {ram_rdata[6:0], 1'b0, ram_rdata[14:8], 1'b0,
                           ram_rdata[22:16], 1'b0, f_xyz_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fcnt_r <= '0;
    end else begin
      if (f_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (out_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      fcnt_r <= fcnt_r + CNTW'(f_push) - CNTW'(out_pop);
    end
  end

endmodule

/* bench/testbench.sv */
// Testbench for the lidar point projection and colorize block: streams pixel writes and points.
`timescale 1ns / 1ps

module testbench;

  // One input transaction as the sender sees it.
  typedef struct {
    lppc_pkg::req_t     kind;
    logic [9:0]         row;
    logic [9:0]         col;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } lidar_req_t;

  // One colored point as the block should return it.
  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } colored_pt_t;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam longint ONE_Q16  = 64'sd65536;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // pix_row, pix_col, pix_blue, pix_green, pix_red, point_x, point_y, point_z, zero fill
  logic [119:0] in_tdata;
  // req_type
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  // out_x, out_y, out_z, color_red, color_green, color_blue
  logic [95:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [lppc_pkg::CFG_AW-1:0] cfg_paddr;
  logic [lppc_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [lppc_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  lidar_point_project_colorize_top dut (.*);

  // Shadow copy of the block's registers and of the pixels written so far.
  logic [63:0] proj_shadow [6];
  logic [10:0] width_shadow;
  logic [10:0] height_shadow;
  logic [23:0] frame_shadow [int];

  lidar_req_t  pending_reqs [$];
  colored_pt_t expected_pts [$];

  int errors;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_tag;
  int hold_seen;
  int hold_cnt;
  logic in_taken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: presents the head of the pending queue, holding it until it is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(pending_reqs.pop_front());
      end
      if (!(in_tvalid && !in_taken)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].kind;
          in_tdata  <= {4'b0, pending_reqs[0].z, pending_reqs[0].y, pending_reqs[0].x,
                        pending_reqs[0].red, pending_reqs[0].green, pending_reqs[0].blue,
                        pending_reqs[0].col, pending_reqs[0].row};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with a long hold-off whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_tag != hold_seen) begin
        hold_seen  <= hold_tag;
        hold_cnt   <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: compares each colored point with the oldest expectation.
  always @(posedge clk) begin
    colored_pt_t exp_pt;
    in_taken <= in_tvalid && in_tready;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      if (expected_pts.size() == 0) begin
        $error("unexpected colored point %h", out_tdata);
        errors <= errors + 1;
      end else begin
        exp_pt = expected_pts.pop_front();
        if (out_tdata[23:0] !== exp_pt.x) begin
          $error("out_x expected %h got %h", exp_pt.x, out_tdata[23:0]);
          errors <= errors + 1;
        end
        if (out_tdata[47:24] !== exp_pt.y) begin
          $error("out_y expected %h got %h", exp_pt.y, out_tdata[47:24]);
          errors <= errors + 1;
        end
        if (out_tdata[71:48] !== exp_pt.z) begin
          $error("out_z expected %h got %h", exp_pt.z, out_tdata[71:48]);
          errors <= errors + 1;
        end
        if (out_tdata[79:72] !== exp_pt.red) begin
          $error("color_red expected %h got %h", exp_pt.red, out_tdata[79:72]);
          errors <= errors + 1;
        end
        if (out_tdata[87:80] !== exp_pt.green) begin
          $error("color_green expected %h got %h", exp_pt.green, out_tdata[87:80]);
          errors <= errors + 1;
        end
        if (out_tdata[95:88] !== exp_pt.blue) begin
          $error("color_blue expected %h got %h", exp_pt.blue, out_tdata[95:88]);
          errors <= errors + 1;
        end
      end
    end
  end

  // One projection row in Q.32: three coefficient products plus the shifted offset.
  function automatic longint project_row(int r, lidar_req_t pt);
    longint k0, k1, k2, k3;
    k0 = longint'($signed(proj_shadow[2*r][31:0]));
    k1 = longint'($signed(proj_shadow[2*r][63:32]));
    k2 = longint'($signed(proj_shadow[2*r+1][31:0]));
    k3 = longint'($signed(proj_shadow[2*r+1][63:32]));
    return k0 * longint'(pt.x) + k1 * longint'(pt.y) + k2 * longint'(pt.z) + k3 * ONE_Q16;
  endfunction

  // Works out the pixel a point lands on; returns 0 when it falls outside the image.
  function automatic bit locate_pixel(lidar_req_t pt, output int pix_key);
    longint u, v, w, col, row, wlim, hlim;
    u = project_row(0, pt);
    v = project_row(1, pt);
    w = project_row(2, pt);
    pix_key = 0;
    if (w == 0) return 1'b0;
    col = u / w;
    row = v / w;
    wlim = (width_shadow > 11'd1024) ? 1024 : longint'(width_shadow);
    hlim = (height_shadow > 11'd1024) ? 1024 : longint'(height_shadow);
    if (col < 0 || col >= wlim || row < 0 || row >= hlim) return 1'b0;
    pix_key = int'(row) * 1024 + int'(col);
    return 1'b1;
  endfunction

  function automatic lidar_req_t pixel_req(int r, int c);
    lidar_req_t p;
    p.kind  = lppc_pkg::REQ_PIXEL;
    p.row   = r[9:0];
    p.col   = c[9:0];
    p.blue  = $urandom();
    p.green = $urandom();
    p.red   = $urandom();
    p.x     = $urandom();
    p.y     = $urandom();
    p.z     = $urandom();
    return p;
  endfunction

  // Queues one transaction and its prediction. A point that would land on a pixel
  // never written gets that pixel written first, so no undefined read is caused.
  task automatic queue_req(lidar_req_t p);
    int key;
    lidar_req_t fill;
    colored_pt_t pt;
    logic [23:0] rgb;
    if (p.kind == lppc_pkg::REQ_PIXEL) begin
      frame_shadow[int'(p.row) * 1024 + int'(p.col)] = {p.red, p.green, p.blue};
      pending_reqs = {pending_reqs, p};
    end else begin
      if (locate_pixel(p, key)) begin
        if (!frame_shadow.exists(key)) begin
          fill = pixel_req(key / 1024, key % 1024);
          queue_req(fill);
        end
        rgb = frame_shadow[key];
        pt.x = p.x;
        pt.y = p.y;
        pt.z = p.z;
        pt.red   = {rgb[22:16], 1'b0};
        pt.green = {rgb[14:8], 1'b0};
        pt.blue  = {rgb[6:0], 1'b0};
        expected_pts = {expected_pts, pt};
      end
      pending_reqs = {pending_reqs, p};
    end
  endtask

  function automatic lidar_req_t point_req(longint x, longint y, longint z);
    lidar_req_t p;
    p = pixel_req(0, 0);
    p.kind = lppc_pkg::REQ_POINT;
    p.x = x[23:0];
    p.y = y[23:0];
    p.z = z[23:0];
    return p;
  endfunction

  // A point, usually in front of a pinhole camera, mostly inside the field of view.
  function automatic lidar_req_t camera_point();
    longint z;
    z = longint'($urandom_range(1, 120)) * ONE_Q16 + $urandom_range(0, 65535);
    if ($urandom_range(7) == 0) z = -z;
    return point_req(z * (int'($urandom_range(0, 800)) - 400) / 100,
                     z * (int'($urandom_range(0, 600)) - 300) / 100, z);
  endfunction

  task automatic cfg_write(lppc_pkg::cfg_reg_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= lppc_pkg::CFG_AW'(8 * int'(idx));
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == lppc_pkg::REG_IMAGE_WIDTH) width_shadow = value[10:0];
    else if (idx == lppc_pkg::REG_IMAGE_HEIGHT) height_shadow = value[10:0];
    else proj_shadow[int'(idx)] = value;
  endtask

  // Pinhole camera: fx = fy = 100, cx = 320, cy = 240, depth taken from z.
  task automatic cfg_camera();
    cfg_write(lppc_pkg::REG_ROW0_LEFT,  {32'd0, 32'd100 << 16});
    cfg_write(lppc_pkg::REG_ROW0_RIGHT, {32'd0, 32'd320 << 16});
    cfg_write(lppc_pkg::REG_ROW1_LEFT,  {32'd100 << 16, 32'd0});
    cfg_write(lppc_pkg::REG_ROW1_RIGHT, {32'd0, 32'd240 << 16});
    cfg_write(lppc_pkg::REG_ROW2_LEFT,  64'd0);
    cfg_write(lppc_pkg::REG_ROW2_RIGHT, {32'd0, 32'd1 << 16});
  endtask

  // Random transactions: mostly points, some random pixel writes, some raw noise.
  task automatic random_mix(int count, bit meters);
    lidar_req_t p;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: queue_req(pixel_req($urandom_range(0, 1023), $urandom_range(0, 1023)));
        2: begin
          p = pixel_req(0, 0);
          p.kind = lppc_pkg::REQ_POINT;
          queue_req(p);
        end
        default: begin
          if (meters) queue_req(point_req($urandom_range(0, 131071), $urandom_range(0, 131071),
                                          $urandom()));
          else queue_req(camera_point());
        end
      endcase
    end
  endtask

  // Waits until every transaction is taken and every colored point has arrived.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_taken = 1'b0;
    errors = 0;
    cycles = 0;
    hold_tag = 0;
    hold_seen = 0;
    hold_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 6; i++) proj_shadow[i] = '0;
    width_shadow = 11'd640;
    height_shadow = 11'd480;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: store corners, extreme coordinates, zero and negative depth.
    cfg_camera();
    queue_req(pixel_req(0, 0));
    queue_req(pixel_req(1023, 1023));
    queue_req(pixel_req(1023, 0));
    queue_req(pixel_req(0, 1023));
    queue_req(point_req(0, 0, ONE_Q16));
    queue_req(point_req(0, 0, 0));
    queue_req(point_req(0, 0, -ONE_Q16));
    queue_req(point_req(-32 * ONE_Q16, -24 * ONE_Q16, 10 * ONE_Q16));
    queue_req(point_req(32 * ONE_Q16 - 1, 24 * ONE_Q16 - 1, 10 * ONE_Q16));
    queue_req(point_req(32 * ONE_Q16, 0, 10 * ONE_Q16));
    queue_req(point_req(-8388608, -8388608, -8388608));
    queue_req(point_req(8388607, 8388607, 8388607));
    queue_req(point_req(-8388608, 8388607, 8388607));
    queue_req(point_req(3 * ONE_Q16, -2 * ONE_Q16, -ONE_Q16));
    drain();

    // Full-size frame with a slow sender.
    cfg_write(lppc_pkg::REG_IMAGE_WIDTH, 64'd1024);
    cfg_write(lppc_pkg::REG_IMAGE_HEIGHT, 64'd1024);
    send_idle_pct = 88;
    random_mix(130, 1'b0);
    drain();

    // Meter grid onto a one-pixel image with a slow receiver.
    cfg_write(lppc_pkg::REG_ROW0_LEFT, {32'd0, 32'd1 << 16});
    cfg_write(lppc_pkg::REG_ROW0_RIGHT, 64'd0);
    cfg_write(lppc_pkg::REG_ROW1_LEFT, {32'd1 << 16, 32'd0});
    cfg_write(lppc_pkg::REG_ROW1_RIGHT, 64'd0);
    cfg_write(lppc_pkg::REG_ROW2_RIGHT, {32'd1 << 16, 32'd0});
    cfg_write(lppc_pkg::REG_IMAGE_WIDTH, 64'd1);
    cfg_write(lppc_pkg::REG_IMAGE_HEIGHT, 64'd1);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    random_mix(130, 1'b1);
    drain();

    // Sizes beyond the store clamp to it; both sides idle now and then.
    cfg_camera();
    cfg_write(lppc_pkg::REG_IMAGE_WIDTH, 64'd2047);
    cfg_write(lppc_pkg::REG_IMAGE_HEIGHT, 64'd2047);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    random_mix(130, 1'b0);
    drain();

    // Extreme coefficients and a zero-size image: nothing may come out.
    cfg_write(lppc_pkg::REG_ROW0_LEFT, 64'h7FFF_FFFF_8000_0000);
    cfg_write(lppc_pkg::REG_ROW0_RIGHT, 64'h8000_0000_7FFF_FFFF);
    cfg_write(lppc_pkg::REG_ROW1_LEFT, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(lppc_pkg::REG_ROW1_RIGHT, 64'h8000_0000_8000_0000);
    cfg_write(lppc_pkg::REG_ROW2_LEFT, 64'h7FFF_FFFF_7FFF_FFFF);
    cfg_write(lppc_pkg::REG_ROW2_RIGHT, 64'h0000_0001_FFFF_FFFF);
    cfg_write(lppc_pkg::REG_IMAGE_WIDTH, 64'd0);
    cfg_write(lppc_pkg::REG_IMAGE_HEIGHT, 64'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_mix(80, 1'b0);
    drain();

    // Random coefficients on a mid-size image.
    for (int i = 0; i < 6; i++) cfg_write(lppc_pkg::cfg_reg_t'(i), {$urandom(), $urandom()});
    cfg_write(lppc_pkg::REG_IMAGE_WIDTH, 64'd640);
    cfg_write(lppc_pkg::REG_IMAGE_HEIGHT, 64'd480);
    random_mix(60, 1'b0);
    drain();

    // Receiver holds off for a long stretch while the sender keeps offering points,
    // so the result buffer fills and the block must stall its input.
    cfg_camera();
    hold_tag = hold_tag + 1;
    random_mix(150, 1'b0);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lppc_pkg.sv
rtl/core/lppc_ram.sv
rtl/core/lppc_div.sv
rtl/core/lidar_point_project_colorize_top.sv
bench/testbench.sv
